[hw/rtl/canaf_pkg.sv]
package canaf_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_CONFIG = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    // Result status carried on the output tuser.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // Register select, taken from paddr[2].
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_RTR    = 1'b1;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 88;
    localparam logic [3:0] MAX_LEN = 4'd8;

    // Input item, last declared field in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic [63:0] frame_data;
        logic [3:0]  frame_length;
        logic        frame_rtr;
        logic [10:0] frame_ident;
        logic        filter_rtr;
        logic [10:0] filter_mask;
        logic [10:0] filter_ident;
        logic [3:0]  entry_index;
    } in_item_t;

    // Result item, last declared field in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic [63:0] out_data;
        logic [3:0]  out_length;
        logic [10:0] out_ident;
        logic [3:0]  matched_entry;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Zero the payload bytes at or above the length.
    function automatic logic [63:0] trim_payload(input logic [63:0] data,
                                                 input logic [3:0] len);
        logic [63:0] res;
        res = '0;
        for (int b = 0; b < 8; b++)
        begin
            res[b*8 +: 8] = (4'(b) < len) ? data[b*8 +: 8] : 8'h00;
        end
        return res;
    endfunction

endpackage

[hw/rtl/can_rx_acceptance_filter_bank.sv]
// CAN receive acceptance filter bank for standard identifiers.
// Input items arrive on s_axis; tuser holds the kind (configure entry,
// clear all entries, received frame) and tdata the entry or frame fields.
// Every input item gives exactly one result item on m_axis; tuser holds the
// status and tdata the matched entry and the accepted frame.
// Configure and clear items need no scan; their result moves into the output
// register once that register is free.
// A frame item scans the valid entries in index order through one shared
// compare unit fed by a synchronous table read, one entry per cycle, and
// stops at the first hit; only entries below min(active_entries, ENTRIES)
// are scanned.
// s_axis_tready is high only while the sequencer is idle, so the next item
// is taken the cycle after the previous result has moved into the output
// register.
// When the receiver stalls, the output register holds its item, one more
// item may be accepted and worked through, and it then waits until the
// output register frees up.
// Reset clears the registers, all entry valid bits and the output valid.
// The registers active_entries and rtr_enable are written over the APB port.
module can_rx_acceptance_filter_bank #(
    parameter int ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index[3:0], filter_ident[14:4], filter_mask[25:15],
    // filter_rtr[26], frame_ident[37:27], frame_rtr[38],
    // frame_length[42:39], frame_data[106:43], zero pad above.
    input  logic [canaf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    // Result items.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // matched_entry[3:0], out_ident[14:4], out_length[18:15],
    // out_data[82:19], zero pad above.
    output logic [canaf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int WW   = 23;

    canaf_pkg::state_t    state_reg, state_next;
    canaf_pkg::in_item_t  in_item;
    canaf_pkg::out_item_t out_item;

    logic [4:0]         active_reg;
    logic               rtr_enable_reg;
    logic [ENTRIES-1:0] entry_valid_reg;

    // Entry table: {mask[10:0], rtr, ident[10:0]}.
    logic [WW-1:0]      entry_mem [ENTRIES];
    logic [WW-1:0]      rd_word_reg;
    logic [CW-1:0]      rd_idx_reg;
    logic               rd_pend_reg;
    logic               rd_valid_reg;

    logic [CW-1:0]      issue_cnt_reg;
    logic [CW-1:0]      scan_lim_reg;
    logic [11:0]        key_reg;

    logic [1:0]         res_status_reg;
    logic [3:0]         res_entry_reg;
    logic [10:0]        frm_ident_reg;
    logic [3:0]         frm_len_reg;
    logic [63:0]        frm_data_reg;

    logic [1:0]         out_status_reg;
    logic [3:0]         out_entry_reg;
    logic [10:0]        out_ident_reg;
    logic [3:0]         out_len_reg;
    logic [63:0]        out_data_reg;
    logic               out_valid_reg;

    logic               in_fire;
    logic               cfg_write;
    logic [CMPW-1:0]    limit;
    logic               cfg_legal;
    logic               issue;
    logic               hit;
    logic               scan_end;
    logic               out_load;
    logic [3:0]         sat_len;

    assign in_item = canaf_pkg::in_item_t'(s_axis_tdata);

    // Handshakes.
    assign s_axis_tready = (state_reg == canaf_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;

    // Entries in use: the smaller of the register and the bank size.
    assign limit = (CMPW'(active_reg) < CMPW'(ENTRIES)) ? CMPW'(active_reg)
                                                         : CMPW'(ENTRIES);

    assign cfg_legal = (CMPW'(in_item.entry_index) < limit)
                    && !(in_item.filter_rtr && !rtr_enable_reg);

    assign sat_len = (in_item.frame_length > canaf_pkg::MAX_LEN) ? canaf_pkg::MAX_LEN
                                                                 : in_item.frame_length;

    // Scan control: compare the entry read last cycle, issue the next read.
    assign hit = rd_pend_reg && rd_valid_reg
              && (((key_reg ^ rd_word_reg[11:0]) & {1'b1, rd_word_reg[22:12]}) == 12'd0);
    assign scan_end = (state_reg == canaf_pkg::ST_SCAN) && !hit
                   && (issue_cnt_reg == scan_lim_reg);
    assign issue = (state_reg == canaf_pkg::ST_SCAN) && !hit
                && (issue_cnt_reg != scan_lim_reg);

    assign out_load = (state_reg == canaf_pkg::ST_DONE)
                   && (!out_valid_reg || m_axis_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            canaf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (s_axis_tuser == canaf_pkg::KIND_FRAME) ? canaf_pkg::ST_SCAN
                                                                         : canaf_pkg::ST_DONE;
                end
            end
            canaf_pkg::ST_SCAN:
            begin
                if (hit || scan_end)
                begin
                    state_next = canaf_pkg::ST_DONE;
                end
            end
            canaf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = canaf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = canaf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= canaf_pkg::ST_IDLE;
            active_reg      <= '0;
            rtr_enable_reg  <= 1'b0;
            entry_valid_reg <= '0;
            rd_pend_reg     <= 1'b0;
            rd_valid_reg    <= 1'b0;
            issue_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes.
            if (cfg_write)
            begin
                unique case (paddr[2])
                    canaf_pkg::REG_ACTIVE: active_reg     <= pwdata[4:0];
                    canaf_pkg::REG_RTR:    rtr_enable_reg <= pwdata[0];
                    default:               active_reg     <= active_reg;
                endcase
            end

            // Valid bits: set on a legal configure, cleared by a clear item.
            if (in_fire && (s_axis_tuser == canaf_pkg::KIND_CONFIG) && cfg_legal)
            begin
                entry_valid_reg[AW'(in_item.entry_index)] <= 1'b1;
            end
            else if (in_fire && (s_axis_tuser == canaf_pkg::KIND_CLEAR))
            begin
                entry_valid_reg <= '0;
            end

            // Scan read pipeline.
            if (in_fire)
            begin
                issue_cnt_reg <= '0;
                rd_pend_reg   <= 1'b0;
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
                rd_pend_reg   <= 1'b1;
                rd_valid_reg  <= entry_valid_reg[issue_cnt_reg[AW-1:0]];
            end
            else
            begin
                rd_pend_reg <= 1'b0;
            end

            // Output register.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Entry table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_fire && (s_axis_tuser == canaf_pkg::KIND_CONFIG) && cfg_legal)
        begin
            entry_mem[AW'(in_item.entry_index)] <= {in_item.filter_mask,
                                                    in_item.filter_rtr,
                                                    in_item.filter_ident};
        end
        if (issue)
        begin
            rd_word_reg <= entry_mem[issue_cnt_reg[AW-1:0]];
            rd_idx_reg  <= issue_cnt_reg;
        end
    end

    // Item payload and result.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scan_lim_reg <= CW'(limit);
            key_reg      <= {in_item.frame_rtr, in_item.frame_ident};
            res_entry_reg <= 4'd0;
            priority if (s_axis_tuser == canaf_pkg::KIND_FRAME)
            begin
                res_status_reg <= canaf_pkg::ST_NOMATCH;
                frm_ident_reg  <= in_item.frame_ident;
                frm_len_reg    <= sat_len;
                frm_data_reg   <= canaf_pkg::trim_payload(in_item.frame_data, sat_len);
            end
            else
            begin
                frm_ident_reg <= '0;
                frm_len_reg   <= '0;
                frm_data_reg  <= '0;
                if (s_axis_tuser == canaf_pkg::KIND_CLEAR
                    || (s_axis_tuser == canaf_pkg::KIND_CONFIG && cfg_legal))
                begin
                    res_status_reg <= canaf_pkg::ST_OK;
                end
                else
                begin
                    res_status_reg <= canaf_pkg::ST_ILLEGAL;
                end
            end
        end
        else if ((state_reg == canaf_pkg::ST_SCAN) && hit)
        begin
            res_status_reg <= canaf_pkg::ST_OK;
            res_entry_reg  <= 4'(rd_idx_reg);
        end
        else if (scan_end)
        begin
            frm_ident_reg <= '0;
            frm_len_reg   <= '0;
            frm_data_reg  <= '0;
        end

        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_ident_reg  <= frm_ident_reg;
            out_len_reg    <= frm_len_reg;
            out_data_reg   <= frm_data_reg;
        end
    end

    // Result item packing.
    always_comb
    begin
        out_item               = '0;
        out_item.matched_entry = out_entry_reg;
        out_item.out_ident     = out_ident_reg;
        out_item.out_length    = out_len_reg;
        out_item.out_data      = out_data_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item;
    assign m_axis_tuser  = out_status_reg;

    // Register read-back.
    always_comb
    begin
        unique case (paddr[2])
            canaf_pkg::REG_ACTIVE: prdata = {27'd0, active_reg};
            canaf_pkg::REG_RTR:    prdata = {31'd0, rtr_enable_reg};
            default:               prdata = 32'd0;
        endcase
    end

endmodule
